// File: src/gpv_pkg.sv
// ----------------------------------------------------------------------------
// gpv_pkg
// Shared types, constants, microcode table and helpers for the gray-plane
// VFD refresh block.
// ----------------------------------------------------------------------------
package gpv_pkg;

    localparam int DIGITS         = 8;
    localparam int COLS_PER_DIGIT = 5;
    localparam int MAX_PLANES     = 8;

    localparam int WIDTH_COLS = DIGITS * COLS_PER_DIGIT;
    localparam int STORE_SIZE = MAX_PLANES * WIDTH_COLS;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    localparam int DIGIT_W    = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int COL_W      = $clog2(COLS_PER_DIGIT + 2);
    localparam int PLANE_W    = $clog2(MAX_PLANES + 1);

    localparam logic OP_DRAW    = 1'b0;
    localparam logic OP_REFRESH = 1'b1;

    localparam logic [1:0] REG_PLANES_IN_USE = 2'd0;
    localparam logic [1:0] REG_MIRRORED      = 2'd1;
    localparam logic [1:0] REG_CGRAM_CMD     = 2'd2;
    localparam logic [1:0] REG_DCRAM_CMD     = 2'd3;

    typedef struct packed {
        logic       opcode;
        logic [5:0] column;
        logic [2:0] row;
        logic [7:0] color;
        logic [2:0] plane;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_command;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [3:0] planes_in_use;
        logic       mirrored;
        logic [7:0] cgram_write_cmd;
        logic [7:0] dcram_write_cmd;
    } t_cfg;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_D_CHECK,
        S_D_READ,
        S_D_WRITE,
        S_R_CMD,
        S_R_COL,
        S_R_DIGIT,
        S_R_DCRAM,
        S_R_IDX
    } t_step;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_CGRAM,
        EM_DATA,
        EM_DCRAM,
        EM_INDEX
    } t_emit;

    typedef enum logic [1:0] {
        AS_CLEAR,
        AS_DRAW,
        AS_REFR
    } t_asel;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_CLR,
        CNT_INC
    } t_cnt_op;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_START,
        C_REFRESH,
        C_SKIP,
        C_K_LAST,
        C_J_DONE,
        C_I_LAST,
        C_CLR_LAST
    } t_cond;

    typedef struct packed {
        t_emit   emit;
        logic    rd;
        logic    wr;
        t_asel   asel;
        logic    ld_gray;
        t_cnt_op k_op;
        t_cnt_op j_op;
        t_cnt_op i_op;
        t_cond   cond;
        t_step   jt;
        t_step   jf;
    } t_ctrl;

    typedef struct packed {
        logic refresh;
        logic skip;
        logic k_last;
        logic j_done;
        logic i_last;
        logic clr_last;
    } t_flags;

    function automatic logic [7:0] flip_byte(input logic [7:0] d);
        logic [7:0] r;
        for (int b = 0; b < 8; b++) begin
            r[7 - b] = d[b];
        end
        return r >> 1;
    endfunction

    function automatic t_ctrl ucode_rom(input t_step s);
        t_ctrl cw;
        cw = '{emit: EM_NONE, rd: 1'b0, wr: 1'b0, asel: AS_CLEAR, ld_gray: 1'b0,
               k_op: CNT_HOLD, j_op: CNT_HOLD, i_op: CNT_HOLD,
               cond: C_ALWAYS, jt: S_IDLE, jf: S_IDLE};
        unique case (s)
            S_CLEAR: begin
                cw.wr   = 1'b1;
                cw.asel = AS_CLEAR;
                cw.cond = C_CLR_LAST;
                cw.jt   = S_IDLE;
                cw.jf   = S_CLEAR;
            end
            S_IDLE: begin
                cw.k_op = CNT_CLR;
                cw.j_op = CNT_CLR;
                cw.i_op = CNT_CLR;
                cw.cond = C_START;
                cw.jt   = S_DISPATCH;
                cw.jf   = S_IDLE;
            end
            S_DISPATCH: begin
                cw.ld_gray = 1'b1;
                cw.cond    = C_REFRESH;
                cw.jt      = S_R_CMD;
                cw.jf      = S_D_CHECK;
            end
            S_D_CHECK: begin
                cw.cond = C_SKIP;
                cw.jt   = S_IDLE;
                cw.jf   = S_D_READ;
            end
            S_D_READ: begin
                cw.rd   = 1'b1;
                cw.asel = AS_DRAW;
                cw.jt   = S_D_WRITE;
                cw.jf   = S_D_WRITE;
            end
            S_D_WRITE: begin
                cw.wr   = 1'b1;
                cw.asel = AS_DRAW;
                cw.k_op = CNT_INC;
                cw.cond = C_K_LAST;
                cw.jt   = S_IDLE;
                cw.jf   = S_D_READ;
            end
            S_R_CMD: begin
                cw.emit = EM_CGRAM;
                cw.rd   = 1'b1;
                cw.asel = AS_REFR;
                cw.j_op = CNT_INC;
                cw.jt   = S_R_COL;
                cw.jf   = S_R_COL;
            end
            S_R_COL: begin
                cw.emit = EM_DATA;
                cw.rd   = 1'b1;
                cw.asel = AS_REFR;
                cw.j_op = CNT_INC;
                cw.cond = C_J_DONE;
                cw.jt   = S_R_DIGIT;
                cw.jf   = S_R_COL;
            end
            S_R_DIGIT: begin
                cw.j_op = CNT_CLR;
                cw.i_op = CNT_INC;
                cw.cond = C_I_LAST;
                cw.jt   = S_R_DCRAM;
                cw.jf   = S_R_CMD;
            end
            S_R_DCRAM: begin
                cw.emit = EM_DCRAM;
                cw.i_op = CNT_CLR;
                cw.jt   = S_R_IDX;
                cw.jf   = S_R_IDX;
            end
            S_R_IDX: begin
                cw.emit = EM_INDEX;
                cw.i_op = CNT_INC;
                cw.cond = C_I_LAST;
                cw.jt   = S_IDLE;
                cw.jf   = S_R_IDX;
            end
            default: begin
                cw.jt = S_IDLE;
                cw.jf = S_IDLE;
            end
        endcase
        return cw;
    endfunction

endpackage

// File: src/gpv_ram.sv
// ----------------------------------------------------------------------------
// gpv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gpv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 320
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/gpv_cfg.sv
// ----------------------------------------------------------------------------
// gpv_cfg
// APB-style register file for plane count, mirroring and command bytes.
// ----------------------------------------------------------------------------
module gpv_cfg
    import gpv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_comb begin
        n_cfg  = r_cfg;
        prdata = '0;
        unique case (reg_idx)
            REG_PLANES_IN_USE: begin
                prdata = {28'd0, r_cfg.planes_in_use};
                if (wr_en) n_cfg.planes_in_use = pwdata[3:0];
            end
            REG_MIRRORED: begin
                prdata = {31'd0, r_cfg.mirrored};
                if (wr_en) n_cfg.mirrored = pwdata[0];
            end
            REG_CGRAM_CMD: begin
                prdata = {24'd0, r_cfg.cgram_write_cmd};
                if (wr_en) n_cfg.cgram_write_cmd = pwdata[7:0];
            end
            REG_DCRAM_CMD: begin
                prdata = {24'd0, r_cfg.dcram_write_cmd};
                if (wr_en) n_cfg.dcram_write_cmd = pwdata[7:0];
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.planes_in_use   <= 4'd8;
            r_cfg.mirrored        <= 1'b0;
            r_cfg.cgram_write_cmd <= 8'd64;
            r_cfg.dcram_write_cmd <= 8'd32;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: src/gpv_seq.sv
// ----------------------------------------------------------------------------
// gpv_seq
// Microcode sequencer: step register, control word lookup, conditional jump.
// ----------------------------------------------------------------------------
module gpv_seq
    import gpv_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  t_flags i_flags,
    output t_ctrl  o_ctrl,
    output logic   o_busy
);

    t_step r_pc;
    t_step n_pc;
    t_ctrl cw;
    logic  taken;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_CLEAR;
        end else begin
            r_pc <= n_pc;
        end
    end

    always_comb begin
        cw = ucode_rom(r_pc);
        unique case (cw.cond)
            C_ALWAYS:   taken = 1'b1;
            C_START:    taken = i_start;
            C_REFRESH:  taken = i_flags.refresh;
            C_SKIP:     taken = i_flags.skip;
            C_K_LAST:   taken = i_flags.k_last;
            C_J_DONE:   taken = i_flags.j_done;
            C_I_LAST:   taken = i_flags.i_last;
            C_CLR_LAST: taken = i_flags.clr_last;
            default:    taken = 1'b1;
        endcase
        n_pc = taken ? cw.jt : cw.jf;
    end

    assign o_ctrl = cw;
    assign o_busy = (r_pc != S_IDLE);

endmodule

// File: src/gpv_datapath.sv
// ----------------------------------------------------------------------------
// gpv_datapath
// Item latch, counters, address generation, plane store and result register.
// ----------------------------------------------------------------------------
module gpv_datapath
    import gpv_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    input  t_ctrl     i_ctrl,
    output t_flags    o_flags,
    output logic      o_strobe,
    output t_out_item o_result
);

    t_in_item           r_item;
    logic [PLANE_W-1:0] r_gray;
    logic [PLANE_W-1:0] n_gray;
    logic [PLANE_W-1:0] r_k;
    logic [PLANE_W-1:0] n_k;
    logic [COL_W-1:0]   r_j;
    logic [COL_W-1:0]   n_j;
    logic [DIGIT_W-1:0] r_i;
    logic [DIGIT_W-1:0] n_i;
    logic [ADDR_W-1:0]  r_clr;
    logic               r_strobe;
    t_out_item          r_result;
    logic               n_strobe;
    t_out_item          n_result;

    logic [PLANE_W-1:0] p_eff;
    logic [15:0]        prod;
    logic [15:0]        gsum;
    logic               plane_ok;
    logic [ADDR_W-1:0]  draw_addr;
    logic [ADDR_W-1:0]  refr_addr;
    logic [ADDR_W-1:0]  mem_addr;
    logic               mem_re;
    logic               mem_we;
    logic [7:0]         mem_wdata;
    logic [7:0]         mem_rdata;
    logic [7:0]         draw_byte;
    logic [7:0]         col_byte;
    logic [DIGIT_W-1:0] idx;
    int                 src;

    always_comb begin
        if (int'(i_cfg.planes_in_use) > MAX_PLANES) begin
            p_eff = PLANE_W'(MAX_PLANES);
        end else begin
            p_eff = PLANE_W'(i_cfg.planes_in_use);
        end
        prod   = 16'(r_item.color) * 16'(p_eff);
        gsum   = prod + 16'd1 + (prod >> 8);
        n_gray = PLANE_W'(gsum >> 8);
    end

    assign plane_ok = (int'(r_item.plane) < MAX_PLANES);

    always_comb begin
        src = i_cfg.mirrored ? (COLS_PER_DIGIT - 1 - int'(r_j)) : int'(r_j);
        draw_addr = ADDR_W'(int'(r_k) * WIDTH_COLS + int'(r_item.column));
        refr_addr = ADDR_W'((plane_ok ? int'(r_item.plane) * WIDTH_COLS : 0)
                    + int'(r_i) * COLS_PER_DIGIT + src);
        unique case (i_ctrl.asel)
            AS_CLEAR: mem_addr = r_clr;
            AS_DRAW:  mem_addr = draw_addr;
            AS_REFR:  mem_addr = refr_addr;
            default:  mem_addr = r_clr;
        endcase
        draw_byte = mem_rdata;
        draw_byte[r_item.row] = (r_k < r_gray);
        mem_wdata = (i_ctrl.asel == AS_DRAW) ? draw_byte : 8'd0;
        mem_we    = i_ctrl.wr;
        mem_re    = i_ctrl.rd && (int'(r_j) < COLS_PER_DIGIT);
    end

    gpv_ram #(
        .WIDTH(8),
        .DEPTH(STORE_SIZE)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_addr),
        .i_wdata(mem_wdata),
        .i_re   (mem_re),
        .i_raddr(mem_addr),
        .o_rdata(mem_rdata)
    );

    always_comb begin
        o_flags.refresh  = (r_item.opcode == OP_REFRESH);
        o_flags.skip     = (int'(r_item.column) >= WIDTH_COLS) || (p_eff == '0);
        o_flags.k_last   = (r_k == p_eff - PLANE_W'(1));
        o_flags.j_done   = (r_j == COL_W'(COLS_PER_DIGIT));
        o_flags.i_last   = (r_i == DIGIT_W'(DIGITS - 1));
        o_flags.clr_last = (r_clr == ADDR_W'(STORE_SIZE - 1));
    end

    always_comb begin
        unique case (i_ctrl.k_op)
            CNT_CLR: n_k = '0;
            CNT_INC: n_k = r_k + PLANE_W'(1);
            default: n_k = r_k;
        endcase
        unique case (i_ctrl.j_op)
            CNT_CLR: n_j = '0;
            CNT_INC: n_j = r_j + COL_W'(1);
            default: n_j = r_j;
        endcase
        unique case (i_ctrl.i_op)
            CNT_CLR: n_i = '0;
            CNT_INC: n_i = r_i + DIGIT_W'(1);
            default: n_i = r_i;
        endcase
    end

    always_comb begin
        col_byte = plane_ok ? (i_cfg.mirrored ? flip_byte(mem_rdata) : mem_rdata) : 8'd0;
        idx      = i_cfg.mirrored ? (DIGIT_W'(DIGITS - 1) - r_i) : r_i;
        n_strobe = 1'b1;
        n_result = '{out_byte: 8'd0, end_of_command: 1'b0, last: 1'b0};
        unique case (i_ctrl.emit)
            EM_CGRAM: n_result.out_byte = i_cfg.cgram_write_cmd | 8'(r_i);
            EM_DATA: begin
                n_result.out_byte       = col_byte;
                n_result.end_of_command = o_flags.j_done;
            end
            EM_DCRAM: n_result.out_byte = i_cfg.dcram_write_cmd;
            EM_INDEX: begin
                n_result.out_byte       = 8'(idx);
                n_result.end_of_command = o_flags.i_last;
                n_result.last           = o_flags.i_last;
            end
            default: n_strobe = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_item <= i_item;
        end
        if (i_ctrl.ld_gray) begin
            r_gray <= n_gray;
        end
        r_result <= n_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k      <= '0;
            r_j      <= '0;
            r_i      <= '0;
            r_clr    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_k      <= n_k;
            r_j      <= n_j;
            r_i      <= n_i;
            r_strobe <= n_strobe;
            if (i_ctrl.wr && i_ctrl.asel == AS_CLEAR) begin
                r_clr <= r_clr + ADDR_W'(1);
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// File: src/gray_plane_vfd_refresh.sv
// ----------------------------------------------------------------------------
// gray_plane_vfd_refresh
// Bit-plane framebuffer and refresh byte streamer for a character VFD.
//
// Usage: an item is taken when start is high and busy is low. A draw item
// scales its color to a gray level and sets or clears one pixel bit in each
// plane in use. A refresh item streams one plane: per digit a glyph command
// byte and its column bytes, then a digit-memory command and the indices.
// Results appear on o_result for one cycle each, marked by o_strobe; the
// receiver takes every result and cannot stall the block.
// Busy stays high while an item is worked: a draw does one read and one
// write of the store per plane in use, and none when its column is out of
// range or no plane is in use. A refresh does one store read per column
// byte; its first byte, the glyph command of digit 0, is emitted from the
// command step that follows the dispatch step and is registered.
// Reset: step register, counters, strobe and configuration are reset (not
// the item, gray and result registers); the store is swept to zero, one entry
// a cycle, with busy high; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module gray_plane_vfd_refresh
    import gpv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in_item    i_item,
    output logic        o_strobe,
    output t_out_item   o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg   cfg;
    t_ctrl  ctrl;
    t_flags flags;
    logic   accept;

    assign accept = start & ~busy;

    gpv_cfg u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .o_cfg  (cfg)
    );

    gpv_seq u_seq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_flags(flags),
        .o_ctrl (ctrl),
        .o_busy (busy)
    );

    gpv_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_item  (i_item),
        .i_cfg   (cfg),
        .i_ctrl  (ctrl),
        .o_flags (flags),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

endmodule
